// ----- design/hptr_pkg.sv -----
`default_nettype none
package hptr_pkg;

  // Geometry defaults and fixed sizes
  localparam int BUCKET_BITS_DEF = 10;
  localparam int WAYS_DEF        = 4;
  localparam int BANKS           = 3;
  localparam int FLOW_W          = 17;
  localparam int WIN_W           = 16;
  localparam int DIVIDEND_W      = 74;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 17;

  localparam logic [31:0]       HASH_SEED       = 32'd5381;
  localparam logic [2:0]        HASH_STEPS      = 3'd4;
  localparam logic [FLOW_W-1:0] MAX_FLOWS_RESET = 17'd65536;
  localparam logic [WIN_W-1:0]  WINDOW_RESET    = 16'd2000;
  localparam logic [63:0]       V4_MASK         = 64'hFFFF_FFFF_0000_0000;

  typedef enum logic [1:0] {
    OP_ACCUM  = 2'd0,
    OP_START  = 2'd1,
    OP_COMMIT = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_DROP_LIMIT = 2'd1,
    ST_DROP_FULL  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_FLOWS = 1'b0,
    REG_WINDOW_MS = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_VREAD,
    BK_VWAIT,
    BK_EREAD,
    BK_ECHECK,
    BK_UPDATE,
    BK_DELTA,
    BK_RATE,
    BK_WAIT,
    BK_SWEEP,
    BK_RESULT
  } bk_state_t;

  typedef struct packed {
    op_t         operation;
    logic        family;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [63:0] orig_bytes;
    logic [63:0] reply_bytes;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        ready_res;
    logic [63:0] upload_rate;
    logic [63:0] download_rate;
  } out_item_t;

  // One table entry as stored in the entry memory
  typedef struct packed {
    logic        family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [63:0] upload_sum;
    logic [63:0] download_sum;
  } entry_t;

  // Four hash rounds: h = h*33 ^ byte, most significant byte first
  function automatic logic [31:0] hash_word(input logic [31:0] h_in, input logic [31:0] w);
    logic [31:0] h;
    h = h_in;
    for (int i = 3; i >= 0; i--) begin
      h = ((h << 5) + h) ^ {24'd0, w[i*8 +: 8]};
    end
    return h;
  endfunction

  function automatic logic [1:0] bank_next(input logic [1:0] b);
    return (b == 2'd2) ? 2'd0 : b + 2'd1;
  endfunction

  function automatic logic [1:0] bank_prev(input logic [1:0] b);
    return (b == 2'd0) ? 2'd2 : b - 2'd1;
  endfunction

endpackage
`default_nettype wire

// ----- design/per_host_traffic_rate_table.sv -----
// Front: four hash steps of four address bytes each, then the queue transfer. Back, from queue
// pop to result: accumulate reads the valid row and the ways, then updates; query reads two
// banks and divides (one quotient bit per cycle); start sweeps the fill bank's valid rows;
// commit or a drop at the flow limit goes straight to the result. The back takes one item at
// a time; the front hashes the next meanwhile. Reset (rst, synchronous): a clearing pass zeroes
// the valid rows; full stays high until it ends. Configuration writes are taken at any time.
`default_nettype none
module per_host_traffic_rate_table #(
  parameter int BUCKET_BITS = hptr_pkg::BUCKET_BITS_DEF,
  parameter int WAYS        = hptr_pkg::WAYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  hptr_pkg::in_item_t               flow,
  input  logic                             pop,
  output logic                             empty,
  output hptr_pkg::out_item_t              result,
  input  logic                             wr_en,
  input  logic [hptr_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [hptr_pkg::CFG_DATA_W-1:0]  wr_data
);
  import hptr_pkg::*;

  localparam int QW = $bits(in_item_t) + BUCKET_BITS;

  logic [FLOW_W-1:0] max_flows;
  logic [WIN_W-1:0]  win_period;
  logic              clearing;
  logic              front_busy;
  logic              q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]     q_in, q_out;

  assign full = front_busy || clearing;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_flows  <= MAX_FLOWS_RESET;
      win_period <= WINDOW_RESET;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_MAX_FLOWS: max_flows  <= wr_data[FLOW_W-1:0];
        REG_WINDOW_MS: win_period <= wr_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  hptr_front #(.BUCKET_BITS(BUCKET_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push && !clearing),
    .busy   (front_busy),
    .item   (flow),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  hptr_fifo #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  hptr_back #(.BUCKET_BITS(BUCKET_BITS), .WAYS(WAYS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .max_flows  (max_flows),
    .win_period (win_period),
    .clearing   (clearing),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule
`default_nettype wire

// ----- design/hptr_ram.sv -----
`default_nettype none
module hptr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/hptr_front.sv -----
`default_nettype none
module hptr_front #(
  parameter int BUCKET_BITS = hptr_pkg::BUCKET_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  output logic                                     busy,
  input  hptr_pkg::in_item_t                       item,
  input  logic                                     q_full,
  output logic                                     q_push,
  output logic [$bits(hptr_pkg::in_item_t)+BUCKET_BITS-1:0] q_data
);
  import hptr_pkg::*;

  logic [2:0]   hcnt;
  logic [31:0]  h;
  logic [127:0] sh;
  in_item_t     cur;
  in_item_t     masked;
  logic         accept;

  // IPv4 keeps only the first four address bytes
  always_comb begin
    masked = item;
    if (!item.family) begin
      masked.address_high = item.address_high & V4_MASK;
      masked.address_low  = '0;
    end
  end

  assign accept = push && !busy;
  assign q_push = busy && (hcnt == HASH_STEPS) && !q_full;
  assign q_data = {h[BUCKET_BITS-1:0], cur};

  // Control: busy from accept until the hashed transfer enters the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      hcnt <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      hcnt <= '0;
    end else if (busy && hcnt != HASH_STEPS) begin
      hcnt <= hcnt + 3'd1;
    end else if (q_push) begin
      busy <= 1'b0;
    end
  end

  // Hash datapath: four address bytes per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= masked;
      h   <= HASH_SEED;
      sh  <= {masked.address_high, masked.address_low};
    end else if (busy && hcnt != HASH_STEPS) begin
      h  <= hash_word(h, sh[127:96]);
      sh <= {sh[95:0], 32'd0};
    end
  end

endmodule
`default_nettype wire

// ----- design/hptr_fifo.sv -----
`default_nettype none
module hptr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  // Two-entry queue between front and back
  logic [WIDTH-1:0] slots [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (pop && !empty) rp <= ~rp;
      case ({push && !full, pop && !empty})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slots[wp] <= din;
  end

endmodule
`default_nettype wire

// ----- design/hptr_div.sv -----
`default_nettype none
module hptr_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [63:0]                  delta,
  input  logic [hptr_pkg::WIN_W-1:0]   divisor,
  output logic                         busy,
  output logic [63:0]                  rate
);
  import hptr_pkg::*;

  localparam logic [6:0] DIV_LAST = 7'(DIVIDEND_W - 1);

  logic [DIVIDEND_W-1:0] n;
  logic [WIN_W-1:0]      rem;
  logic [6:0]            cnt;
  logic [DIVIDEND_W-1:0] scaled;
  logic [WIN_W:0]        rem_sh;
  logic [WIN_W:0]        rem_sub;
  logic                  ge;

  // delta * 1000 as (d << 10) - (d << 4) - (d << 3)
  assign scaled = (DIVIDEND_W'(delta) << 10) - (DIVIDEND_W'(delta) << 4)
                - (DIVIDEND_W'(delta) << 3);

  // Restoring division, one quotient bit per cycle
  assign rem_sh  = {rem, n[DIVIDEND_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign ge      = (rem_sh >= {1'b0, divisor});

  // Saturate quotients beyond 64 bits
  assign rate = (|n[DIVIDEND_W-1:64]) ? '1 : n[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == DIV_LAST) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n   <= scaled;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      n   <= {n[DIVIDEND_W-2:0], ge};
      rem <= ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
      cnt <= cnt + 7'd1;
    end
  end

endmodule
`default_nettype wire

// ----- design/hptr_back.sv -----
`default_nettype none
module hptr_back #(
  parameter int BUCKET_BITS = hptr_pkg::BUCKET_BITS_DEF,
  parameter int WAYS        = hptr_pkg::WAYS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     q_empty,
  input  logic [$bits(hptr_pkg::in_item_t)+BUCKET_BITS-1:0] q_data,
  output logic                                     q_pop,
  input  logic [hptr_pkg::FLOW_W-1:0]              max_flows,
  input  logic [hptr_pkg::WIN_W-1:0]               win_period,
  output logic                                     clearing,
  input  logic                                     pop,
  output logic                                     empty,
  output hptr_pkg::out_item_t                      result
);
  import hptr_pkg::*;

  localparam int BB   = BUCKET_BITS;
  localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int VA_W = BB + 2;
  localparam int EA_W = BB + 2 + WW;
  localparam int V_DEPTH = BANKS * (2 ** BB);
  localparam int E_DEPTH = BANKS * (2 ** (BB + WW));
  localparam logic [VA_W-1:0] CLEAR_LAST  = VA_W'(V_DEPTH - 1);
  localparam logic [BB-1:0]   BUCKET_LAST = '1;
  localparam logic [WW-1:0]   WAY_LAST    = WW'(WAYS - 1);

  bk_state_t       state, state_next;
  logic [1:0]      fb;
  logic            nyc;
  logic [FLOW_W-1:0] flows_seen;
  logic [VA_W-1:0] cnt;
  in_item_t        cur;
  in_item_t        q_item;
  logic [BB-1:0]   q_bucket;
  logic [BB-1:0]   bucket;
  logic [1:0]      bank;
  logic            phase;
  logic [WW-1:0]   way;
  logic [WAYS-1:0] vrow;
  logic            hit;
  logic [WW-1:0]   hit_way;
  logic [63:0]     a_up, a_down, b_up, b_down;
  status_t         r_status;
  logic [63:0]     r_up, r_down;
  logic            res_valid;
  logic            res_free;

  logic            v_we;
  logic [VA_W-1:0] v_waddr;
  logic [WAYS-1:0] v_wdata;
  logic [WAYS-1:0] v_rdata;
  logic            e_we;
  logic [EA_W-1:0] e_waddr;
  entry_t          e_wdata;
  logic [$bits(entry_t)-1:0] e_rdata;
  entry_t          e;
  logic            match;
  logic            free_ok;
  logic [WW-1:0]   free_way;
  logic            div_start;
  logic            up_busy, dn_busy;
  logic [63:0]     up_rate, dn_rate;

  assign {q_bucket, q_item} = q_data;
  assign e        = entry_t'(e_rdata);
  assign clearing = (state == BK_CLEAR);
  assign res_free = !res_valid || pop;
  assign empty    = !res_valid;

  // Way compare against the current key
  assign match = vrow[way] && (e.family == cur.family) &&
                 (e.addr_high == cur.address_high) && (e.addr_low == cur.address_low);

  // Lowest free way of the bucket
  always_comb begin
    free_ok  = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vrow[w]) begin
        free_ok  = 1'b1;
        free_way = WW'(w);
      end
    end
  end

  // Valid rows: one row of WAYS bits per bank and bucket
  hptr_ram #(.WIDTH(WAYS), .DEPTH(V_DEPTH)) u_vmem (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr ({bank, bucket}),
    .rdata (v_rdata)
  );

  // Entries: key and byte sums
  hptr_ram #(.WIDTH($bits(entry_t)), .DEPTH(E_DEPTH)) u_emem (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr ({bank, bucket, way}),
    .rdata (e_rdata)
  );

  hptr_div u_div_up (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .delta   (a_up),
    .divisor (win_period),
    .busy    (up_busy),
    .rate    (up_rate)
  );

  hptr_div u_div_dn (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .delta   (a_down),
    .divisor (win_period),
    .busy    (dn_busy),
    .rate    (dn_rate)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= BK_CLEAR;
    else     state <= state_next;
  end

  // Next state and memory controls
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    v_we       = 1'b0;
    v_waddr    = {bank, bucket};
    v_wdata    = '0;
    e_we       = 1'b0;
    e_waddr    = {bank, bucket, way};
    e_wdata    = '{cur.family, cur.address_high, cur.address_low,
                   cur.orig_bytes, cur.reply_bytes};
    div_start  = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        v_we    = 1'b1;
        v_waddr = cnt;
        if (cnt == CLEAR_LAST) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_item.operation)
            OP_ACCUM:  state_next = (flows_seen >= max_flows) ? BK_RESULT : BK_VREAD;
            OP_START:  state_next = BK_SWEEP;
            OP_COMMIT: state_next = BK_RESULT;
            OP_QUERY:  state_next = nyc ? BK_RESULT : BK_VREAD;
            default:   state_next = BK_RESULT;
          endcase
        end
      end
      BK_VREAD:  state_next = BK_VWAIT;
      BK_VWAIT:  state_next = BK_EREAD;
      BK_EREAD:  state_next = BK_ECHECK;
      BK_ECHECK: begin
        if (match || way == WAY_LAST) begin
          if (cur.operation == OP_ACCUM) state_next = BK_UPDATE;
          else if (!match)               state_next = BK_RESULT;
          else if (!phase)               state_next = BK_VREAD;
          else                           state_next = BK_DELTA;
        end else begin
          state_next = BK_EREAD;
        end
      end
      BK_UPDATE: begin
        if (hit) begin
          e_we    = 1'b1;
          e_waddr = {bank, bucket, hit_way};
          e_wdata.upload_sum   = a_up + cur.orig_bytes;
          e_wdata.download_sum = a_down + cur.reply_bytes;
        end else if (free_ok) begin
          e_we    = 1'b1;
          e_waddr = {bank, bucket, free_way};
          v_we    = 1'b1;
          v_wdata = vrow;
          v_wdata[free_way] = 1'b1;
        end
        state_next = BK_RESULT;
      end
      BK_DELTA: state_next = BK_RATE;
      BK_RATE: begin
        if (win_period == '0) begin
          state_next = BK_RESULT;
        end else begin
          div_start  = 1'b1;
          state_next = BK_WAIT;
        end
      end
      BK_WAIT: begin
        if (!up_busy && !dn_busy) state_next = BK_RESULT;
      end
      BK_SWEEP: begin
        v_we    = 1'b1;
        v_waddr = {fb, cnt[BB-1:0]};
        if (cnt[BB-1:0] == BUCKET_LAST) state_next = BK_RESULT;
      end
      BK_RESULT: begin
        if (res_free) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Bank rotation, flow count and per-item working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fb         <= 2'd0;
      nyc        <= 1'b1;
      flows_seen <= '0;
      cnt        <= '0;
    end else begin
      case (state)
        BK_CLEAR: cnt <= cnt + 1'b1;
        BK_IDLE: begin
          if (!q_empty) begin
            cur      <= q_item;
            bucket   <= q_bucket;
            r_status <= (q_item.operation == OP_ACCUM && flows_seen >= max_flows) ?
                        ST_DROP_LIMIT : ST_DONE;
            r_up     <= '0;
            r_down   <= '0;
            phase    <= 1'b0;
            cnt      <= '0;
            case (q_item.operation)
              OP_ACCUM: begin
                bank <= fb;
                if (flows_seen < max_flows) flows_seen <= flows_seen + 1'b1;
              end
              OP_START:  flows_seen <= '0;
              OP_COMMIT: begin
                fb  <= bank_next(fb);
                nyc <= 1'b0;
              end
              default: bank <= bank_prev(fb);
            endcase
          end
        end
        BK_VWAIT: begin
          vrow <= v_rdata;
          way  <= '0;
          hit  <= 1'b0;
        end
        BK_ECHECK: begin
          if (match) begin
            hit     <= 1'b1;
            hit_way <= way;
            if (phase) begin
              b_up   <= e.upload_sum;
              b_down <= e.download_sum;
            end else begin
              a_up   <= e.upload_sum;
              a_down <= e.download_sum;
            end
            if (!phase && cur.operation == OP_QUERY) begin
              phase <= 1'b1;
              bank  <= bank_next(fb);
            end
          end else if (way != WAY_LAST) begin
            way <= way + 1'b1;
          end
        end
        BK_UPDATE: begin
          if (!hit && !free_ok) r_status <= ST_DROP_FULL;
        end
        BK_DELTA: begin
          a_up   <= (a_up > b_up) ? a_up - b_up : '0;
          a_down <= (a_down > b_down) ? a_down - b_down : '0;
        end
        BK_WAIT: begin
          if (!up_busy && !dn_busy) begin
            r_up   <= up_rate;
            r_down <= dn_rate;
          end
        end
        BK_SWEEP: cnt <= cnt + 1'b1;
        default: ;
      endcase
    end
  end

  // Result register: holds one finished result until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == BK_RESULT && res_free) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_RESULT && res_free) begin
      result <= '{r_status, !nyc, r_up, r_down};
    end
  end

endmodule
`default_nettype wire
